// ===== hw/rtl/usrng_pkg.sv =====
package usrng_pkg;

	// default ring depth
	localparam int SLOTS_DEF = 5;

	// field and register widths
	localparam int MM_W      = 18;
	localparam int WIDTH_W   = 20;
	localparam int TIMER_W   = 20;
	localparam int SHORT_W   = 16;
	localparam int LONG_W    = 20;
	localparam int CFG_W     = 20;
	localparam int REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_PRE_LEN   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PULSE_LEN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WAIT      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MIN_ECHO  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

	// register reset values
	localparam logic [SHORT_W-1:0] PRE_LEN_RST   = 16'd2;
	localparam logic [SHORT_W-1:0] PULSE_LEN_RST = 16'd10;
	localparam logic [LONG_W-1:0]  WAIT_RST      = 20'd1000;
	localparam logic [SHORT_W-1:0] MIN_ECHO_RST  = 16'd50;
	localparam logic [LONG_W-1:0]  TIMEOUT_RST   = 20'd1000000;

	// mm = floor(width * MM_NUM / MM_DEN), tracked incrementally with a remainder
	localparam int REM_W = 7;
	localparam logic [REM_W-1:0] MM_NUM = 7'd17;
	localparam logic [REM_W-1:0] MM_DEN = 7'd100;

	typedef enum logic [2:0] {
		PH_PRE        = 3'd0,
		PH_PULSE      = 3'd1,
		PH_ECHO_CLEAR = 3'd2,
		PH_ECHO_ARM   = 3'd3,
		PH_ECHO_TIME  = 3'd4,
		PH_WAIT       = 3'd5
	} phase_t;

	typedef struct packed {
		logic [SHORT_W-1:0] pre_len;
		logic [SHORT_W-1:0] pulse_len;
		logic [LONG_W-1:0]  wait_len;
		logic [SHORT_W-1:0] min_echo;
		logic [LONG_W-1:0]  timeout;
	} cfg_t;

	// measurement outcome of one tick
	typedef struct packed {
		logic            done;
		logic            store;
		logic [MM_W-1:0] mm;
	} meas_t;

endpackage

// ===== hw/rtl/usrng_seq.sv =====
module usrng_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              echo,
	input  usrng_pkg::cfg_t   cfg,
	output logic              trig,
	output usrng_pkg::meas_t  meas
);
	import usrng_pkg::*;

	phase_t               phase_q, phase_d;
	logic [TIMER_W-1:0]   timer_q, timer_d;
	logic [WIDTH_W-1:0]   width_q, width_d;
	logic [MM_W-1:0]      mm_q, mm_d;
	logic [REM_W-1:0]     rem_q, rem_d;
	logic [TIMER_W:0]     timer_inc;
	logic [TIMER_W-1:0]   limit;
	logic                 hit;
	logic                 done;
	logic                 store;
	logic [REM_W:0]       rem_add;

	assign timer_inc = {1'b0, timer_q} + {{TIMER_W{1'b0}}, 1'b1};
	assign hit       = timer_inc >= {1'b0, limit};
	assign rem_add   = {1'b0, rem_q} + {1'b0, MM_NUM};

	always_comb begin
		case (phase_q)
			PH_PRE:   limit = TIMER_W'(cfg.pre_len);
			PH_PULSE: limit = TIMER_W'(cfg.pulse_len);
			PH_WAIT:  limit = TIMER_W'(cfg.wait_len);
			default:  limit = TIMER_W'(cfg.timeout);
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		width_d = width_q;
		mm_d    = mm_q;
		rem_d   = rem_q;
		done    = 1'b0;
		store   = 1'b0;
		case (phase_q)
			PH_PRE: begin
				timer_d = timer_inc[TIMER_W-1:0];
				if (hit) begin
					phase_d = PH_PULSE;
					timer_d = '0;
				end
			end
			PH_PULSE: begin
				timer_d = timer_inc[TIMER_W-1:0];
				if (hit) begin
					phase_d = PH_ECHO_CLEAR;
					timer_d = '0;
					width_d = '0;
					mm_d    = '0;
					rem_d   = '0;
				end
			end
			PH_ECHO_CLEAR, PH_ECHO_ARM, PH_ECHO_TIME: begin
				timer_d = timer_inc[TIMER_W-1:0];
				if (phase_q == PH_ECHO_CLEAR) begin
					if (!echo) begin
						phase_d = PH_ECHO_ARM;
					end
				end else if (phase_q == PH_ECHO_ARM) begin
					if (echo) begin
						phase_d = PH_ECHO_TIME;
						width_d = WIDTH_W'(1);
						mm_d    = '0;
						rem_d   = MM_NUM;
					end
				end else if (echo) begin
					width_d = width_q + WIDTH_W'(1);
					if (rem_add >= {1'b0, MM_DEN}) begin
						rem_d = REM_W'(rem_add - {1'b0, MM_DEN});
						mm_d  = mm_q + MM_W'(1);
					end else begin
						rem_d = rem_add[REM_W-1:0];
					end
				end else begin
					// falling edge wins over a timeout on the same tick
					done = 1'b1;
				end
				if (done) begin
					store   = width_q > WIDTH_W'(cfg.min_echo);
					phase_d = PH_WAIT;
					timer_d = '0;
				end else if (hit) begin
					done    = 1'b1;
					width_d = '0;
					mm_d    = '0;
					rem_d   = '0;
					phase_d = PH_WAIT;
					timer_d = '0;
				end
			end
			PH_WAIT: begin
				timer_d = timer_inc[TIMER_W-1:0];
				if (hit) begin
					phase_d = PH_PRE;
					timer_d = '0;
				end
			end
			default: begin
				phase_d = PH_PRE;
				timer_d = '0;
			end
		endcase
	end

	// outputs
	always_comb begin
		trig       = (phase_q == PH_PULSE);
		meas.done  = done;
		meas.store = store;
		meas.mm    = mm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			timer_q <= '0;
			width_q <= '0;
			mm_q    <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			width_q <= width_d;
			mm_q    <= mm_d;
			rem_q   <= rem_d;
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < MM_DEN)
		else $error("mm remainder out of range");

	a_width_timing: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ECHO_TIME |-> width_q != '0)
		else $error("zero width while timing echo");

	a_store_done: assert property (@(posedge clk) disable iff (!arst_n)
		store |-> done && phase_q == PH_ECHO_TIME)
		else $error("sample stored outside echo completion");

endmodule

// ===== hw/rtl/usrng_ring.sv =====
module usrng_ring #(
	parameter int SLOTS = usrng_pkg::SLOTS_DEF,
	parameter int SUM_W = usrng_pkg::MM_W + $clog2(SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  usrng_pkg::meas_t  meas,
	output logic [SUM_W-1:0]  sum_next
);
	import usrng_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	logic [MM_W-1:0]   ring_q [SLOTS];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic              wr;

	assign wr       = step && meas.done && meas.store;
	assign sum_next = (meas.done && meas.store)
		? sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(meas.mm)
		: sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ring_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q  <= '0;
		end else if (wr) begin
			ring_q[slot_q] <= meas.mm;
			slot_q         <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
			sum_q          <= sum_next;
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("write slot past end of ring");

endmodule

// ===== hw/rtl/usrng_avg.sv =====
module usrng_avg #(
	parameter int SLOTS = usrng_pkg::SLOTS_DEF,
	parameter int SUM_W = usrng_pkg::MM_W + $clog2(SLOTS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vld_s2,
	input  logic                       trig_s2,
	input  logic                       done_s2,
	input  logic [SUM_W-1:0]           sum_s2,
	input  logic                       out_ready,
	output logic                       take,
	output logic                       out_valid,
	output logic                       trigger_level,
	output logic                       level_valid,
	output logic [usrng_pkg::MM_W-1:0] level_mm
);
	import usrng_pkg::*;

	// floor(sum / SLOTS) as a reciprocal multiply, exact for every sum below 2^SUM_W
	localparam int SH      = SUM_W + $clog2(SLOTS) + 1;
	localparam int RECIP_W = SH + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SH) / SLOTS) + 64'd1);

	logic [SUM_W+RECIP_W-1:0] prod;
	logic                     out_valid_q;
	logic                     trig_q;
	logic                     done_q;
	logic [MM_W-1:0]          level_q;

	assign prod = {{RECIP_W{1'b0}}, sum_s2} * {{SUM_W{1'b0}}, RECIP};
	assign take = vld_s2 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			trig_q  <= trig_s2;
			done_q  <= done_s2;
			level_q <= prod[SH +: MM_W];
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_level = trig_q;
	assign level_valid   = done_q;
	assign level_mm      = level_q;

endmodule

// ===== hw/rtl/ultrasonic_ranger_with_average.sv =====
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       echo_level
// out       output     out_valid / out_ready     trigger_level, level_valid, level_mm
// cfg       input      cfg_wr_en (no wait)       cfg_index, cfg_data
//
// one request per cycle sustained while out_ready stays high; each request is one microsecond tick
// a result is offered once its request has passed the input register, sequencer/ring stage and result register
// every request gives exactly one result; the ring sum is divided by SLOTS via a reciprocal multiply
// reset clears sequencer, ring and sum at once, no clearing pass
// a stalled result backs up through the two stages into in_ready, nothing is dropped
module ultrasonic_ranger_with_average #(
	parameter int SLOTS = usrng_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            echo_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            trigger_level,
	output logic                            level_valid,
	output logic [usrng_pkg::MM_W-1:0]      level_mm,
	input  logic                            cfg_wr_en,
	input  logic [usrng_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [usrng_pkg::CFG_W-1:0]     cfg_data
);
	import usrng_pkg::*;

	// ring sum needs room for SLOTS samples of the widest distance
	localparam int SUM_W = MM_W + $clog2(SLOTS);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_len   <= PRE_LEN_RST;
			cfg_q.pulse_len <= PULSE_LEN_RST;
			cfg_q.wait_len  <= WAIT_RST;
			cfg_q.min_echo  <= MIN_ECHO_RST;
			cfg_q.timeout   <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PRE_LEN:   cfg_q.pre_len   <= cfg_data[SHORT_W-1:0];
				REG_PULSE_LEN: cfg_q.pulse_len <= cfg_data[SHORT_W-1:0];
				REG_WAIT:      cfg_q.wait_len  <= cfg_data[LONG_W-1:0];
				REG_MIN_ECHO:  cfg_q.min_echo  <= cfg_data[SHORT_W-1:0];
				REG_TIMEOUT:   cfg_q.timeout   <= cfg_data[LONG_W-1:0];
				default: ; // unused indexes are dropped
			endcase
		end
	end

	// stage control: s1 holds the sampled echo, s2 holds the tick's outcome
	logic             vld_s1;
	logic             echo_s1;
	logic             vld_s2;
	logic             trig_s2;
	logic             done_s2;
	logic [SUM_W-1:0] sum_s2;
	logic             take;   // s2 moves into the result register
	logic             adv;    // s1 moves into s2, sequencer state steps

	assign adv      = vld_s1 && (!vld_s2 || take);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			echo_s1 <= echo_level;
		end
	end

	// phase sequencer and echo width / mm tracking
	logic  trig;
	meas_t meas;

	usrng_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.echo   (echo_s1),
		.cfg    (cfg_q),
		.trig   (trig),
		.meas   (meas)
	);

	// sample ring with running sum
	logic [SUM_W-1:0] sum_next;

	usrng_ring #(
		.SLOTS (SLOTS),
		.SUM_W (SUM_W)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.meas     (meas),
		.sum_next (sum_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (take) begin
			vld_s2 <= 1'b0;
		end
	end

	// sum after this tick; its average is always the latest reported distance
	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s2 <= trig;
			done_s2 <= meas.done;
			sum_s2  <= sum_next;
		end
	end

	// average and result register
	usrng_avg #(
		.SLOTS (SLOTS),
		.SUM_W (SUM_W)
	) u_avg (
		.clk           (clk),
		.arst_n        (arst_n),
		.vld_s2        (vld_s2),
		.trig_s2       (trig_s2),
		.done_s2       (done_s2),
		.sum_s2        (sum_s2),
		.out_ready     (out_ready),
		.take          (take),
		.out_valid     (out_valid),
		.trigger_level (trigger_level),
		.level_valid   (level_valid),
		.level_mm      (level_mm)
	);

	// a measurement can only complete in an echo phase, never with the trigger high
	a_done_no_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_valid |-> !trigger_level)
		else $error("measurement reported with trigger high");

endmodule
